// ===== design/ils_pkg.sv =====
// Shared types and codes for the indexed list store.
package ils_pkg;

   // Operation codes carried in req_tuser
   localparam logic [3:0] ACT_PUSH    = 4'd0;
   localparam logic [3:0] ACT_POP     = 4'd1;
   localparam logic [3:0] ACT_INSERT  = 4'd2;
   localparam logic [3:0] ACT_DELETE  = 4'd3;
   localparam logic [3:0] ACT_SWAP    = 4'd4;
   localparam logic [3:0] ACT_READ    = 4'd5;
   localparam logic [3:0] ACT_FIND    = 4'd6;
   localparam logic [3:0] ACT_DROP    = 4'd7;
   localparam logic [3:0] ACT_RESET   = 4'd8;
   localparam logic [3:0] ACT_CLEAR   = 4'd9;
   localparam logic [3:0] ACT_RESERVE = 4'd10;

   // Result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   localparam int unsigned WORD_W = 64;

   typedef enum logic [2:0] {
      CM_HOLD,
      CM_ROTATE,
      CM_INSERT,
      CM_DELETE,
      CM_CLEAR
   } cell_mode_type;

   // Broadcast control for every cell of the row
   typedef struct packed {
      cell_mode_type mode;
      logic          zero_head;
   } cell_ctl_type;

endpackage

// ===== design/ils_cell.sv =====
// One storage cell of the list row: holds a word, shifts or rotates with its neighbours.
module ils_cell import ils_pkg::*; #(
   parameter int unsigned IDX = 0,
   parameter int unsigned CW  = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [CW-1:0]     slot,
   input  logic [CW-1:0]     lim,
   input  logic [WORD_W-1:0] item,
   input  logic [WORD_W-1:0] left_val,
   input  logic [WORD_W-1:0] right_val,
   output logic [WORD_W-1:0] entry
);

   localparam logic [CW-1:0] MY = CW'(IDX);

   logic [WORD_W-1:0] entry_ff;
   logic [WORD_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.mode)
         CM_ROTATE: begin
            entry_in = right_val;
         end
         CM_INSERT: begin
            if (MY == slot) begin
               entry_in = item;
            end else if (MY > slot && MY <= lim) begin
               entry_in = left_val;
            end
         end
         CM_DELETE: begin
            // close up the tail behind the removed slot
            if (MY >= slot && MY < lim) begin
               entry_in = right_val;
            end
         end
         CM_CLEAR: begin
            entry_in = '0;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
      if (ctl.zero_head && IDX == 0) begin
         entry_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== design/indexed_list_store.sv =====
// Top level of the indexed list store: a row of word cells under an operation sequencer.
//
//   channel | dir | ports               | content
//   req     | in  | req_t{valid,ready}  | tuser: action; tdata: position, item, drop_count,
//           |     | req_tdata,req_tuser |        reserve_bytes
//   rsp     | out | rsp_t{valid,ready}  | tdata: item_out, index_out, found, status, used_count
//
// Push, insert, drop, reset, clear and reserve finish on the accepting edge: the cells shift or write in
// place and the result word is registered on that same edge.
// Pop, delete, swap, read and find on a non-empty store go through a scan: the row
// rotates once round its ring so that every entry passes the head cell, where it is
// picked or compared, then the finishing state closes up the row after a delete and loads the result.
// Reset is synchronous; it empties the store and zeroes every cell at once.
// A new word is taken only while the sequencer is idle and the result register is free
// or being emptied; a stalled result holds its word and blocks the next operation.
module indexed_list_store import ils_pkg::*; #(
   parameter int unsigned DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] position, [71:8] item, [78:72] drop_count, [88:79] reserve_bytes, [95:89] zero
   input  logic [95:0] req_tdata,
   // [3:0] action
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [63:0] item_out, [70:64] index_out, [71] found, [73:72] status, [80:74] used_count,
   // [87:81] zero
   output logic [87:0] rsp_tdata
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned PW = ((CW > 8) ? CW : 8) + 2;
   localparam int unsigned XW = (CW > 7) ? CW : 7;
   localparam int unsigned SW = ((CW > 8) ? CW : 8) + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } seq_state_type;

   // unpack the request word
   logic [3:0]        action;
   logic [7:0]        position;
   logic [WORD_W-1:0] item;
   logic [6:0]        drop_count;
   logic [9:0]        reserve_bytes;

   assign action        = req_tuser;
   assign position      = req_tdata[7:0];
   assign item          = req_tdata[71:8];
   assign drop_count    = req_tdata[78:72];
   assign reserve_bytes = req_tdata[88:79];

   // sequencer state
   seq_state_type     state_ff, state_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [3:0]        op_ff, op_in;
   logic [CW-1:0]     tgt_ff, tgt_in;
   logic [WORD_W-1:0] key_ff, key_in;
   logic [AW-1:0]     k_ff, k_in;
   logic [WORD_W-1:0] cap_ff, cap_in;
   logic              hit_ff, hit_in;
   logic [AW-1:0]     hit_idx_ff, hit_idx_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_item_ff, rsp_item_in;
   logic [6:0]        rsp_index_ff, rsp_index_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [6:0]        rsp_used_ff, rsp_used_in;

   // cell row
   cell_ctl_type      ctl;
   logic [CW-1:0]     slot;
   logic [CW-1:0]     lim;
   logic [WORD_W-1:0] cell_item;
   logic [WORD_W-1:0] feed;
   logic [WORD_W-1:0] ent [DEPTH];

   logic rsp_free;
   logic accept;
   logic is_empty;
   logic is_full;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign accept     = req_tvalid && req_tready;
   assign is_empty   = (fill_ff == '0);
   assign is_full    = (fill_ff >= CW'(DEPTH));

   // position normalising: negative counts back from the end, saturate to first/last
   logic signed [PW-1:0] p_s, f_s, s_s;
   logic [CW-1:0]        norm_slot;

   always_comb begin
      p_s = {{(PW-8){position[7]}}, position};
      f_s = PW'(fill_ff);
      s_s = p_s;
      if (p_s < 0) begin
         s_s = p_s + f_s;
         if (s_s < 0) begin
            s_s = '0;
         end
      end
      if (s_s >= f_s) begin
         s_s = f_s - PW'(1);
      end
      norm_slot = s_s[CW-1:0];
   end

   // drop and reserve arithmetic
   logic [XW-1:0] d_x, f_x;
   logic [7:0]    res_slots;
   logic [SW-1:0] res_sum;

   assign d_x       = XW'(drop_count);
   assign f_x       = XW'(fill_ff);
   assign res_slots = 8'(reserve_bytes[9:3]) + 8'(|reserve_bytes[2:0]);
   assign res_sum   = SW'(fill_ff) + SW'(res_slots);

   // swap replaces the word as it leaves the head on its way round the ring
   assign feed = (op_ff == ACT_SWAP && CW'(k_ff) == tgt_ff) ? key_ff : ent[0];

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      op_in         = op_ff;
      tgt_in        = tgt_ff;
      key_in        = key_ff;
      k_in          = k_ff;
      cap_in        = cap_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_item_in   = rsp_item_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      ctl.mode      = CM_HOLD;
      ctl.zero_head = 1'b0;
      slot          = fill_ff;
      lim           = fill_ff;
      cell_item     = item;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // direct operations answer on this edge unless switched to a scan below
               rsp_valid_in  = 1'b1;
               rsp_item_in   = '0;
               rsp_index_in  = '0;
               rsp_found_in  = 1'b0;
               rsp_status_in = STAT_OK;
               op_in         = action;
               key_in        = item;
               tgt_in        = norm_slot;
               k_in          = '0;
               hit_in        = 1'b0;
               hit_idx_in    = '0;
               case (action)
                  ACT_PUSH, ACT_INSERT: begin
                     if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        ctl.mode = CM_INSERT;
                        if (action == ACT_PUSH || is_empty || p_s == f_s) begin
                           slot = fill_ff;
                        end else begin
                           slot = norm_slot;
                        end
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  ACT_POP, ACT_DELETE, ACT_SWAP, ACT_READ: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        state_in     = S_SCAN;
                        if (action == ACT_POP) begin
                           tgt_in = fill_ff - CW'(1);
                        end
                     end
                  end
                  ACT_FIND: begin
                     if (!is_empty) begin
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        state_in     = S_SCAN;
                     end
                  end
                  ACT_DROP: begin
                     if (f_x >= d_x) begin
                        fill_in      = CW'(f_x - d_x);
                        rsp_index_in = drop_count;
                     end else begin
                        fill_in      = '0;
                        rsp_index_in = 7'(fill_ff);
                     end
                  end
                  ACT_RESET: begin
                     fill_in = '0;
                  end
                  ACT_CLEAR: begin
                     ctl.mode = CM_CLEAR;
                     fill_in  = '0;
                  end
                  ACT_RESERVE: begin
                     if (res_sum <= SW'(DEPTH)) begin
                        rsp_index_in = 7'(fill_ff);
                        fill_in      = CW'(res_sum);
                     end else begin
                        rsp_status_in = STAT_FULL;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
               rsp_used_in = 7'(fill_in);
            end
         end

         S_SCAN: begin
            // advance the ring one place; entry k_ff sits in the head cell
            ctl.mode = CM_ROTATE;
            if (CW'(k_ff) == tgt_ff) begin
               cap_in = ent[0];
            end
            // only a find records a match
            if (op_ff == ACT_FIND && !hit_ff && CW'(k_ff) < fill_ff && ent[0] == key_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = k_ff;
            end
            if (k_ff == AW'(DEPTH - 1)) begin
               k_in     = '0;
               state_in = S_FINISH;
            end else begin
               k_in = k_ff + AW'(1);
            end
         end

         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_item_in   = cap_ff;
               rsp_index_in  = '0;
               rsp_found_in  = 1'b0;
               rsp_status_in = STAT_OK;
               case (op_ff)
                  ACT_POP: begin
                     fill_in       = fill_ff - CW'(1);
                     ctl.zero_head = (fill_in == '0);
                  end
                  ACT_DELETE: begin
                     fill_in       = fill_ff - CW'(1);
                     ctl.mode      = CM_DELETE;
                     slot          = tgt_ff;
                     lim           = fill_in;
                     ctl.zero_head = (fill_in == '0);
                  end
                  ACT_FIND: begin
                     rsp_item_in  = '0;
                     rsp_found_in = hit_ff;
                     rsp_index_in = hit_ff ? 7'(hit_idx_ff) : 7'd0;
                  end
                  default: begin
                     rsp_item_in = cap_ff;
                  end
               endcase
               rsp_used_in = 7'(fill_in);
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         k_ff         <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         k_ff         <= k_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      tgt_ff        <= tgt_in;
      key_ff        <= key_in;
      cap_ff        <= cap_in;
      hit_idx_ff    <= hit_idx_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // the row: each cell takes from its left neighbour on insert and its right on
   // delete or rotate; the last cell closes the ring through the head feed
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] left_val;
      logic [WORD_W-1:0] right_val;
      if (i == 0) begin : g_first
         assign left_val = '0;
      end else begin : g_inner_l
         assign left_val = ent[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_val = feed;
      end else begin : g_inner_r
         assign right_val = ent[i+1];
      end
      ils_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .slot      (slot),
         .lim       (lim),
         .item      (cell_item),
         .left_val  (left_val),
         .right_val (right_val),
         .entry     (ent[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_used_ff, rsp_status_ff, rsp_found_ff, rsp_index_ff,
                        rsp_item_ff};

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill level beyond capacity");

   a_scan_counter_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_SCAN |-> k_ff == '0)
      else $error("ring counter not at home outside a scan");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_PUSH && !is_full |=> fill_ff == $past(fill_ff) + CW'(1))
      else $error("push did not grow the list");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> CW'(hit_idx_ff) < fill_ff)
      else $error("find hit beyond used entries");

   a_scan_holds_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |=> fill_ff == $past(fill_ff))
      else $error("fill level moved during a scan");
`endif

endmodule
